/* sv/mfe_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the FIFO-fed Manchester line encoder.
// No dependencies; every module of the block imports this package.
package mfe_pkg;

	// Byte FIFO geometry
	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int OUT_CNT_W  = 7;

	// Classified-beat queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Tick divider and half-bit sequencing
	localparam int TICK_W = 8;
	localparam int HBL_W  = 5;
	localparam logic [TICK_W-1:0] HALF_BIT_TICKS_RST = 8'd4;
	localparam logic [TICK_W-1:0] TICK_CNT_RST       = 8'd1;

	localparam logic [7:0] IDLE_PATTERN  = 8'hC0;
	localparam logic [7:0] START_PATTERN = 8'h80;

	localparam logic [HBL_W-1:0] IDLE_HALF_BITS  = 5'd8;
	localparam logic [HBL_W-1:0] START_HALF_BITS = 5'd2;
	localparam logic [HBL_W-1:0] DATA_HALF_BITS  = 5'd16;

	// Command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// One classified beat, from front to back
	typedef struct packed {
		logic                 expire;     // divider expired: next half-bit goes out
		logic                 load;       // load a new pattern into the shifter
		logic [7:0]           load_byte;  // pattern or popped data byte
		logic                 shift;      // second half of a bit: advance shifter
		logic                 invert;     // send inverse of current bit
		logic                 accepted;   // push stored its byte
		logic                 empty;      // FIFO empty after this beat
		logic [OUT_CNT_W-1:0] count;      // FIFO fill after this beat
	} mfe_rec_t;

endpackage

/* sv/mfe_front.sv */
`timescale 1ns / 1ps
// Front end: accepts beats, owns the byte FIFO, tick divider and half-bit
// sequencing, and emits one classified record per beat. Uses mfe_pkg.
module mfe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             command,
	input  logic [7:0]       data_byte,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data,
	output logic             rec_valid,
	input  logic             rec_ready,
	output mfe_pkg::mfe_rec_t rec
);
	import mfe_pkg::*;

	logic [7:0]         mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_idx_q, rd_idx_q, wr_idx_nxt, rd_idx_nxt, rd_addr;
	logic [CNT_W-1:0]   count_q, count_nxt;
	logic [TICK_W-1:0]  tick_cnt_q, half_bit_ticks_q;
	logic [HBL_W-1:0]   hbl_q, hbl_eff;
	logic               run_q, run_nxt;
	logic [7:0]         head_q;

	logic accept, full, push_ok, expire, need_load, idle_sel, start_sel, pop, odd;

	// Config register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_ticks_q <= HALF_BIT_TICKS_RST;
		end else if (cfg_valid) begin
			half_bit_ticks_q <= cfg_data;
		end
	end

	assign rec_valid = in_valid;
	assign in_ready  = rec_ready;

	// Classify the beat
	always_comb begin
		accept    = in_valid & rec_ready;
		full      = (count_q == CNT_W'(FIFO_DEPTH));
		push_ok   = accept & (command == CMD_PUSH) & ~full;
		expire    = accept & (command == CMD_TICK) & (tick_cnt_q == TICK_CNT_RST);
		need_load = expire & (hbl_q == '0);
		idle_sel  = (count_q == '0);
		start_sel = ~idle_sel & ~run_q;
		pop       = need_load & ~idle_sel & run_q;

		hbl_eff = hbl_q;
		run_nxt = run_q;
		if (need_load) begin
			if (idle_sel) begin
				hbl_eff = IDLE_HALF_BITS;
				run_nxt = 1'b0;
			end else if (start_sel) begin
				hbl_eff = START_HALF_BITS;
				run_nxt = 1'b1;
			end else begin
				hbl_eff = DATA_HALF_BITS;
			end
		end
		odd = hbl_eff[0];

		count_nxt = count_q;
		if (push_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (pop) begin
			count_nxt = count_q - CNT_W'(1);
		end

		wr_idx_nxt = wr_idx_q;
		if (push_ok) begin
			wr_idx_nxt = (wr_idx_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_idx_q + FIFO_AW'(1);
		end
		rd_idx_nxt = rd_idx_q;
		if (pop) begin
			rd_idx_nxt = (rd_idx_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_idx_q + FIFO_AW'(1);
		end
		rd_addr = rd_idx_nxt;

		rec.expire    = expire;
		rec.load      = need_load;
		rec.load_byte = idle_sel ? IDLE_PATTERN : (start_sel ? START_PATTERN : head_q);
		rec.shift     = odd;
		rec.invert    = odd & run_nxt;
		rec.accepted  = push_ok;
		rec.empty     = (count_nxt == '0);
		rec.count     = OUT_CNT_W'(count_nxt);
	end

	// FIFO storage; head byte is prefetched with write-first bypass
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_idx_q] <= data_byte;
		end
		if (push_ok && (wr_idx_q == rd_addr)) begin
			head_q <= data_byte;
		end else begin
			head_q <= mem[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			count_q    <= '0;
			tick_cnt_q <= TICK_CNT_RST;
			hbl_q      <= '0;
			run_q      <= 1'b0;
		end else begin
			wr_idx_q <= wr_idx_nxt;
			rd_idx_q <= rd_idx_nxt;
			count_q  <= count_nxt;
			if (accept && (command == CMD_TICK)) begin
				tick_cnt_q <= expire ? half_bit_ticks_q : tick_cnt_q - TICK_W'(1);
			end
			if (expire) begin
				hbl_q <= hbl_eff - HBL_W'(1);
				run_q <= run_nxt;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("FIFO fill exceeds depth");
	a_hbl_range: assert property (@(posedge clk) disable iff (!arst_n)
		hbl_q < DATA_HALF_BITS)
		else $error("half-bit counter out of range");
	a_idle_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(need_load && idle_sel) |=> !run_q)
		else $error("idle pattern did not close the data run");
`endif

endmodule

/* sv/mfe_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified records between front and back ends.
// Uses mfe_pkg for the record type and depth.
module mfe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  mfe_pkg::mfe_rec_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output mfe_pkg::mfe_rec_t pop_data
);
	import mfe_pkg::*;

	mfe_rec_t            entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0] cnt_q;
	logic                do_push, do_pop;

	assign push_ready = (cnt_q != QUEUE_CW'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_AW'(1);
			end
			cnt_q <= cnt_q + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
		end
	end

`ifndef ASSERT_OFF
	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - QUEUE_CW'(1)))
		else $error("queue fill did not drop on pop");
`endif

endmodule

/* sv/mfe_back.sv */
`timescale 1ns / 1ps
// Back end: half-bit shifter and held line level, plus the result register.
// Uses mfe_pkg for the record type.
module mfe_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rec_valid,
	output logic                           rec_ready,
	input  mfe_pkg::mfe_rec_t              rec,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           line_level,
	output logic                           push_accepted,
	output logic                           fifo_empty,
	output logic [mfe_pkg::OUT_CNT_W-1:0]  fifo_count
);
	import mfe_pkg::*;

	logic                 out_valid_q, level_q, line_q, acc_q, empty_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic [7:0]           shift_q, sb;
	logic                 take, lvl;

	assign rec_ready = ~out_valid_q | out_ready;
	assign take      = rec_valid & rec_ready;

	// Current pattern bit, inverted on the second half of a data or start bit
	assign sb  = rec.load ? rec.load_byte : shift_q;
	assign lvl = sb[7] ^ rec.invert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			level_q     <= 1'b0;
			shift_q     <= '0;
		end else begin
			out_valid_q <= take | (out_valid_q & ~out_ready);
			if (take && rec.expire) begin
				level_q <= lvl;
				shift_q <= rec.shift ? {sb[6:0], 1'b0} : sb;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			line_q  <= rec.expire ? lvl : level_q;
			acc_q   <= rec.accepted;
			empty_q <= rec.empty;
			count_q <= rec.count;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_level    = line_q;
	assign push_accepted = acc_q;
	assign fifo_empty    = empty_q;
	assign fifo_count    = count_q;

endmodule

/* sv/fifo_manchester_line_encoder.sv */
`timescale 1ns / 1ps
// Manchester line encoder fed from a 64-byte FIFO; top level.
// Instantiates mfe_front, mfe_queue and mfe_back; uses mfe_pkg.

// Takes one beat per clock, either a byte push or a sample tick, and returns
// one result beat per input beat in order: the held line level, whether a
// push was stored, and the FIFO empty flag and fill count after that beat.
// A beat is classified in the front end in its acceptance cycle, waits in a
// two-entry record queue, and is applied by the back end into the result
// register; sustained rate is one beat per clock while out_ready stays high.
// The half-bit length register is written through the cfg channel (always
// ready) and should be changed only while no beats are in flight.
module fifo_manchester_line_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       line_level,
	output logic       push_accepted,
	output logic       fifo_empty,
	output logic [6:0] fifo_count,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import mfe_pkg::*;

	mfe_rec_t front_rec, back_rec;
	logic     front_valid, front_ready, back_valid, back_ready;

	mfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.data_byte (data_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rec_valid (front_valid),
		.rec_ready (front_ready),
		.rec       (front_rec)
	);

	mfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_rec),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_rec)
	);

	mfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (back_valid),
		.rec_ready     (back_ready),
		.rec           (back_rec),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.line_level    (line_level),
		.push_accepted (push_accepted),
		.fifo_empty    (fifo_empty),
		.fifo_count    (fifo_count)
	);

endmodule
